@@ rtl/sspq_pkg.sv @@
package sspq_pkg;

    localparam int TAG_BITS = 16;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

    // flags a cell shows its neighbors
    typedef struct packed {
        logic occ;  // cell holds an entry
        logic gt;   // held key is greater than the key being pushed
    } t_cell_flags;

endpackage

@@ rtl/sspq_cell.sv @@
module sspq_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sspq_pkg::t_cell_cmd          i_cmd,
    input  logic [KEY_BITS-1:0]          i_new_key,
    input  logic [sspq_pkg::TAG_BITS-1:0] i_new_tag,
    input  sspq_pkg::t_cell_flags        i_prev_flags,
    input  logic [KEY_BITS-1:0]          i_prev_key,
    input  logic [sspq_pkg::TAG_BITS-1:0] i_prev_tag,
    input  logic                         i_next_occ,
    input  logic [KEY_BITS-1:0]          i_next_key,
    input  logic [sspq_pkg::TAG_BITS-1:0] i_next_tag,
    output sspq_pkg::t_cell_flags        o_flags,
    output logic [KEY_BITS-1:0]          o_key,
    output logic [sspq_pkg::TAG_BITS-1:0] o_tag
);
    import sspq_pkg::*;

    logic                r_occ, n_occ;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                gt;

    assign gt = r_occ && (r_key > i_new_key);

    always_comb begin
        n_occ = r_occ;
        n_key = r_key;
        n_tag = r_tag;
        if (i_cmd.pop) begin
            n_occ = i_next_occ;
            n_key = i_next_key;
            n_tag = i_next_tag;
        end else if (i_cmd.push) begin
            if (i_prev_flags.gt) begin
                // larger entries move one place back
                n_occ = 1'b1;
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else if (i_prev_flags.occ && (!r_occ || gt)) begin
                // first slot behind all keys less or equal
                n_occ = 1'b1;
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_flags.occ = r_occ;
    assign o_flags.gt  = gt;
    assign o_key       = r_key;
    assign o_tag       = r_tag;

endmodule

@@ rtl/stable_sorted_priority_queue.sv @@
// each result is registered and appears in the cycle after its input transfer
// one item per cycle unless stalled; every cell decides its shift in parallel each cycle
// result holds in a single output register, input stalls only while it is full and stalled
// reset (synchronous, active low) empties all cells and the output register
// key and tag storage is not cleared, only the occupied flags are
module stable_sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 16,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [sspq_pkg::TAG_BITS-1:0] i_entry_tag,
    input  logic [KEY_BITS-1:0]           i_base_key,
    input  logic [KEY_BITS-1:0]           i_key_increment,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sspq_pkg::TAG_BITS-1:0] o_out_tag,
    output logic [KEY_BITS-1:0]           o_out_key,
    output logic [1:0]                    o_status,
    output logic [CW-1:0]                 o_occupancy
);
    import sspq_pkg::*;

    // cell chain wiring, index QUEUE_DEPTH-1 is the far end
    t_cell_flags         flags [QUEUE_DEPTH];
    logic [KEY_BITS-1:0] keys  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tags  [QUEUE_DEPTH];

    t_cell_cmd           cmd;
    logic                accept;
    logic                is_push, is_pop, is_peek;
    logic                full, empty;
    logic [KEY_BITS:0]   key_sum;
    logic [KEY_BITS-1:0] new_key;

    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid;
    logic [TAG_BITS-1:0] r_out_tag, n_out_tag;
    logic [KEY_BITS-1:0] r_out_key, n_out_key;
    t_status             r_status, n_status;

    // output register frees up when its result transfers
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_push = (i_action == ACT_PUSH);
    assign is_pop  = (i_action == ACT_POP);
    assign is_peek = (i_action == ACT_PEEK);
    assign full    = (r_count == CW'(QUEUE_DEPTH));
    assign empty   = (r_count == '0);

    // saturating key sum
    assign key_sum = {1'b0, i_base_key} + {1'b0, i_key_increment};
    assign new_key = key_sum[KEY_BITS] ? {KEY_BITS{1'b1}} : key_sum[KEY_BITS-1:0];

    assign cmd.push = accept && is_push && !full;
    assign cmd.pop  = accept && is_pop && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_cell_flags         prev_flags;
            logic [KEY_BITS-1:0] prev_key;
            logic [TAG_BITS-1:0] prev_tag;
            logic                next_occ;
            logic [KEY_BITS-1:0] next_key;
            logic [TAG_BITS-1:0] next_tag;

            if (gi == 0) begin : g_head
                // head cell: nothing in front, always a valid insert point
                assign prev_flags.occ = 1'b1;
                assign prev_flags.gt  = 1'b0;
                assign prev_key       = '0;
                assign prev_tag       = '0;
            end else begin : g_body
                assign prev_flags = flags[gi-1];
                assign prev_key   = keys[gi-1];
                assign prev_tag   = tags[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                // tail cell empties on pop
                assign next_occ = 1'b0;
                assign next_key = '0;
                assign next_tag = '0;
            end else begin : g_mid
                assign next_occ = flags[gi+1].occ;
                assign next_key = keys[gi+1];
                assign next_tag = tags[gi+1];
            end

            sspq_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_new_key    (new_key),
                .i_new_tag    (i_entry_tag),
                .i_prev_flags (prev_flags),
                .i_prev_key   (prev_key),
                .i_prev_tag   (prev_tag),
                .i_next_occ   (next_occ),
                .i_next_key   (next_key),
                .i_next_tag   (next_tag),
                .o_flags      (flags[gi]),
                .o_key        (keys[gi]),
                .o_tag        (tags[gi])
            );
        end
    endgenerate

    // result of the transfer, front entry is always cell 0
    always_comb begin
        n_count   = r_count;
        n_out_tag = '0;
        n_out_key = '0;
        n_status  = ST_OK;
        if (is_push) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (is_pop || is_peek) begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_out_tag = tags[0];
                n_out_key = keys[0];
                if (is_pop) begin
                    n_count = r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out_tag <= n_out_tag;
            r_out_key <= n_out_key;
            r_status  <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tag   = r_out_tag;
    assign o_out_key   = r_out_key;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

endmodule

@@ rtl/sspq_checker.sv @@
module sspq_checker #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 16,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [1:0]                    i_action,
    input logic [sspq_pkg::TAG_BITS-1:0] i_entry_tag,
    input logic [KEY_BITS-1:0]           i_base_key,
    input logic [KEY_BITS-1:0]           i_key_increment,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sspq_pkg::TAG_BITS-1:0] o_out_tag,
    input logic [KEY_BITS-1:0]           o_out_key,
    input logic [1:0]                    o_status,
    input logic [CW-1:0]                 o_occupancy
);
    import sspq_pkg::*;

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_tag)
            && $stable(o_out_key) && $stable(o_status))
        else $error("stalled result changed");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_occupancy == CW'(QUEUE_DEPTH))
        else $error("full refusal with room left");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |->
            (o_occupancy == '0) && (o_out_tag == '0) && (o_out_key == '0))
        else $error("empty refusal with entries or nonzero payload");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

    // one accepted push from an empty queue makes occupancy one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_PUSH) && (o_occupancy == '0)
            |=> o_occupancy == CW'(1))
        else $error("push into empty queue miscounted");

endmodule

bind stable_sorted_priority_queue sspq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_BITS   (KEY_BITS)
) u_sspq_checker (.*);

@@ bench/tb_stable_sorted_priority_queue.sv @@
module tb_stable_sorted_priority_queue;
    import sspq_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int KEY_BITS    = 16;
    localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

    // action code with no meaning, the block must ignore it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // key spreads used by the random phases
    localparam int KEYS_NARROW   = 0;  // many equal keys, checks fifo order on ties
    localparam int KEYS_WIDE     = 1;  // whole key range, all bits toggle
    localparam int KEYS_NEAR_TOP = 2;  // close to the maximum, often saturates

    // traffic mix of a random phase
    typedef enum int {
        MIX_FILL,
        MIX_EMPTY_OUT,
        MIX_ANY
    } t_mix;

    typedef struct {
        logic [1:0]          action;
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] incr;
        bit                  wait_idle;  // hold off until all results are back
    } t_queue_cmd;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef struct {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
        t_status             status;
        logic [OCC_BITS-1:0] occ;
    } t_response;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_action        = ACT_PUSH;
    logic [TAG_BITS-1:0] i_entry_tag     = '0;
    logic [KEY_BITS-1:0] i_base_key      = '0;
    logic [KEY_BITS-1:0] i_key_increment = '0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [TAG_BITS-1:0] o_out_tag;
    logic [KEY_BITS-1:0] o_out_key;
    logic [1:0]          o_status;
    logic [OCC_BITS-1:0] o_occupancy;

    stable_sorted_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_entry_tag     (i_entry_tag),
        .i_base_key      (i_base_key),
        .i_key_increment (i_key_increment),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_tag       (o_out_tag),
        .o_out_key       (o_out_key),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    t_queue_cmd cmd_fifo[$];        // commands not yet offered to the block
    t_entry     sorted_entries[$];  // shadow copy of the queue contents, front is smallest
    t_response  due_results[$];     // responses owed by the block, oldest first
    bit         failed = 1'b0;
    bit         in_xfer = 1'b0;     // input transfer took place at the last rising edge

    // sender pacing
    int         burst_left = 1;
    int         gap_left = 0;
    t_queue_cmd next_cmd;

    // receiver stall pattern
    int         stall_mode = 0;
    int         stall_left = 0;

    t_response  want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("stable_sorted_priority_queue regression: fail");
        $finish;
    end

    // shadow model: apply one command, return the response it owes
    function automatic t_response service_command(logic [1:0] act, logic [TAG_BITS-1:0] tag,
                                                  logic [KEY_BITS-1:0] base,
                                                  logic [KEY_BITS-1:0] incr);
        t_response         r;
        t_entry            e;
        logic [KEY_BITS:0] sum;
        int                pos;
        r.tag    = '0;
        r.key    = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (sorted_entries.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // saturating sum of base and increment
                    sum   = {1'b0, base} + {1'b0, incr};
                    e.key = sum[KEY_BITS] ? {KEY_BITS{1'b1}} : sum[KEY_BITS-1:0];
                    e.tag = tag;
                    // land behind every entry whose key is <= ours
                    pos = 0;
                    while (pos < sorted_entries.size() && sorted_entries[pos].key <= e.key)
                        pos++;
                    sorted_entries.insert(pos, e);
                end
            end
            ACT_POP, ACT_PEEK: begin
                if (sorted_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.tag = sorted_entries[0].tag;
                    r.key = sorted_entries[0].key;
                    if (act == ACT_POP)
                        void'(sorted_entries.pop_front());
                end
            end
            default: ;  // unused code, nothing changes
        endcase
        r.occ = OCC_BITS'(sorted_entries.size());
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] act, logic [TAG_BITS-1:0] tag,
                           logic [KEY_BITS-1:0] base, logic [KEY_BITS-1:0] incr,
                           bit wait_idle);
        t_queue_cmd c;
        c.action    = act;
        c.tag       = tag;
        c.base      = base;
        c.incr      = incr;
        c.wait_idle = wait_idle;
        cmd_fifo.push_back(c);
    endtask

    // monitor: checks result transfers and feeds the shadow model on input transfers
    always @(posedge i_clk) begin
        in_xfer <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no response expected");
                    failed = 1'b1;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_tag !== want.tag) begin
                        $error("out_tag: expected %0h, got %0h", want.tag, o_out_tag);
                        failed = 1'b1;
                    end
                    if (o_out_key !== want.key) begin
                        $error("out_key: expected %0h, got %0h", want.key, o_out_key);
                        failed = 1'b1;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        failed = 1'b1;
                    end
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                        failed = 1'b1;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(service_command(i_action, i_entry_tag, i_base_key,
                                                      i_key_increment));
            end
        end
    end

    // driver: bursts of commands with random gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_xfer)) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_fifo.size() == 0 ||
                         (cmd_fifo[0].wait_idle && due_results.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                next_cmd = cmd_fifo.pop_front();
                i_in_valid      <= 1'b1;
                i_action        <= next_cmd.action;
                i_entry_tag     <= next_cmd.tag;
                i_base_key      <= next_cmd.base;
                i_key_increment <= next_cmd.incr;
                if (burst_left <= 1) begin
                    // last of this burst: pick the next burst and the gap before it
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern picks a new random mode when its countdown runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    initial begin
        int   n_counted;
        int   phase_len;
        int   key_spread;
        int   roll;
        t_mix mix;
        logic [1:0]          act;
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] incr;

        // directed: empty refusals, unused code, extreme keys and tags, ties, saturation
        add_cmd(ACT_POP,    16'h1234, 16'h0000, 16'h0000, 1'b0);
        add_cmd(ACT_PEEK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_cmd(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_cmd(ACT_PUSH,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);  // saturates
        add_cmd(ACT_PUSH,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_cmd(ACT_PUSH,   16'h0001, 16'h8000, 16'h7FFF, 1'b0);  // hits the maximum exactly
        add_cmd(ACT_PUSH,   16'h0002, 16'h0000, 16'h0000, 1'b0);  // tie with key zero
        add_cmd(ACT_PUSH,   16'h0003, 16'h8000, 16'h8000, 1'b0);  // one past the maximum
        add_cmd(ACT_PUSH,   16'hA5A5, 16'h0005, 16'h0000, 1'b0);
        add_cmd(ACT_PEEK,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_cmd(ACT_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        repeat (6) add_cmd(ACT_POP, 16'h5A5A, 16'hFFFF, 16'h0000, 1'b0);
        add_cmd(ACT_POP,    16'h0000, 16'h0000, 16'h0000, 1'b0);  // empty again
        add_cmd(ACT_PEEK,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_cmd(ACT_PUSH,   16'h00FF, 16'h00F0, 16'h000F, 1'b0);

        // random: first phase is push-heavy to fill the queue, then mixed phases
        n_counted = 0;
        mix        = MIX_FILL;
        key_spread = KEYS_NARROW;
        phase_len  = 40;
        while (n_counted < 450) begin
            for (int i = 0; i < phase_len; i++) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:      act = (roll < 85) ? ACT_PUSH : (roll < 95) ? ACT_POP
                                                                              : ACT_PEEK;
                    MIX_EMPTY_OUT: act = (roll < 70) ? ACT_POP : (roll < 85) ? ACT_PEEK
                                                                             : ACT_PUSH;
                    default:       act = (roll < 45) ? ACT_PUSH : (roll < 78) ? ACT_POP :
                                         (roll < 94) ? ACT_PEEK : ACT_UNUSED;
                endcase
                case (key_spread)
                    KEYS_NARROW: begin
                        base = KEY_BITS'($urandom_range(0, 7));
                        incr = KEY_BITS'($urandom_range(0, 1));
                    end
                    KEYS_WIDE: begin
                        base = KEY_BITS'($urandom);
                        incr = $urandom_range(0, 1) ? KEY_BITS'($urandom)
                                                    : KEY_BITS'($urandom_range(0, 255));
                    end
                    default: begin
                        base = KEY_BITS'($urandom_range(16'hFF00, 16'hFFFF));
                        incr = KEY_BITS'($urandom_range(0, 511));
                    end
                endcase
                // the first command of a phase may wait for the block to go idle
                add_cmd(act, TAG_BITS'($urandom), base, incr,
                        (i == 0) && ($urandom_range(0, 3) == 0));
                if (act != ACT_UNUSED)
                    n_counted++;
            end
            mix        = t_mix'($urandom_range(0, 2));
            key_spread = $urandom_range(KEYS_NARROW, KEYS_NEAR_TOP);
            phase_len  = $urandom_range(10, 45);
        end
        // at least one full pause until every response is back
        cmd_fifo[25].wait_idle = 1'b1;

        // reset: held low from the start, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_fifo.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (due_results.size() != 0)
            @(negedge i_clk);
        // wait on to catch any stray result transfer
        repeat (4) @(negedge i_clk);

        if (!failed && due_results.size() == 0) begin
            $display("stable_sorted_priority_queue regression: pass");
        end else begin
            $display("stable_sorted_priority_queue regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sspq_pkg.sv
rtl/sspq_cell.sv
rtl/stable_sorted_priority_queue.sv
rtl/sspq_checker.sv
bench/tb_stable_sorted_priority_queue.sv
